// ===== src/cfa_pkg.sv =====
// shared types and constants for the checked fixed-point alu
`default_nettype none

package cfa_pkg;

  localparam int unsigned DataW   = 64;
  localparam int unsigned HalfW   = DataW / 2;
  localparam int unsigned ProdW   = 2 * DataW;
  localparam int unsigned FracW   = 32;

  // operation codes
  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_QMUL = 2'd2,
    OP_IMUL = 2'd3
  } op_e;

  // stage 1: magnitudes and add/subtract result
  typedef struct packed {
    op_e              op;
    logic             neg;
    logic [DataW-1:0] mag_a;
    logic [DataW-1:0] mag_b;
    logic [DataW-1:0] as_val;
    logic             as_ok;
  } s1_t;

  // stage 2: four partial products
  typedef struct packed {
    op_e              op;
    logic             neg;
    logic [DataW-1:0] as_val;
    logic             as_ok;
    logic [DataW-1:0] pp_ll;
    logic [DataW-1:0] pp_lh;
    logic [DataW-1:0] pp_hl;
    logic [DataW-1:0] pp_hh;
  } s2_t;

  // stage 3: middle terms summed
  typedef struct packed {
    op_e              op;
    logic             neg;
    logic [DataW-1:0] as_val;
    logic             as_ok;
    logic [DataW:0]   mid;
    logic [DataW-1:0] pp_ll;
    logic [DataW-1:0] pp_hh;
  } s3_t;

  // stage 4: full product of magnitudes
  typedef struct packed {
    op_e              op;
    logic             neg;
    logic [DataW-1:0] as_val;
    logic             as_ok;
    logic [ProdW-1:0] prod;
  } s4_t;

  // stage 5: rounded or truncated magnitude with range check
  typedef struct packed {
    op_e              op;
    logic             neg;
    logic [DataW-1:0] as_val;
    logic             as_ok;
    logic [DataW-1:0] mag;
    logic             mag_ovf;
  } s5_t;

endpackage

`default_nettype wire

// ===== src/cfa_front.sv =====
// first stage: operand magnitudes, product sign and checked add/subtract
`default_nettype none

module cfa_front
  import cfa_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    up_valid_i,
  output logic                         up_en_o,
  input  wire logic [1:0]              op_i,
  input  wire logic signed [DataW-1:0] operand_a_i,
  input  wire logic signed [DataW-1:0] operand_b_i,
  output logic                         dn_valid_o,
  input  wire logic                    dn_en_i,
  output s1_t                          dn_data_o
);

  logic             valid_q;
  s1_t              data_d, data_q;
  logic [DataW-1:0] a, b, b_eff, sum;
  logic             is_sub;

  assign a      = operand_a_i;
  assign b      = operand_b_i;
  assign is_sub = (op_e'(op_i) == OP_SUB);

  // one adder serves add and subtract
  assign b_eff = is_sub ? ~b : b;
  assign sum   = a + b_eff + {{(DataW-1){1'b0}}, is_sub};

  always_comb begin
    data_d.op     = op_e'(op_i);
    data_d.neg    = a[DataW-1] ^ b[DataW-1];
    data_d.mag_a  = a[DataW-1] ? (~a + {{(DataW-1){1'b0}}, 1'b1}) : a;
    data_d.mag_b  = b[DataW-1] ? (~b + {{(DataW-1){1'b0}}, 1'b1}) : b;
    data_d.as_val = sum;
    // signed overflow: operands of effective equal sign, result sign differs
    data_d.as_ok  = !((~(a[DataW-1] ^ b_eff[DataW-1])) & (a[DataW-1] ^ sum[DataW-1]));
  end

  assign up_en_o = !valid_q || dn_en_i;

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_en_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_en_o && up_valid_i) begin
      data_q <= data_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule

`default_nettype wire

// ===== src/cfa_mult.sv =====
// three-stage 64x64 magnitude multiplier built from 32x32 partial products
`default_nettype none

module cfa_mult
  import cfa_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic up_valid_i,
  output logic      up_en_o,
  input  wire s1_t  up_data_i,
  output logic      dn_valid_o,
  input  wire logic dn_en_i,
  output s4_t       dn_data_o
);

  logic v2_q, v3_q, v4_q;
  logic en2, en3, en4;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  s4_t  s4_d, s4_q;

  // enables ripple back from the output side
  assign en4     = !v4_q || dn_en_i;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign up_en_o = en2;

  // partial products
  always_comb begin
    s2_d.op     = up_data_i.op;
    s2_d.neg    = up_data_i.neg;
    s2_d.as_val = up_data_i.as_val;
    s2_d.as_ok  = up_data_i.as_ok;
    s2_d.pp_ll  = up_data_i.mag_a[HalfW-1:0] * up_data_i.mag_b[HalfW-1:0];
    s2_d.pp_lh  = up_data_i.mag_a[HalfW-1:0] * up_data_i.mag_b[DataW-1:HalfW];
    s2_d.pp_hl  = up_data_i.mag_a[DataW-1:HalfW] * up_data_i.mag_b[HalfW-1:0];
    s2_d.pp_hh  = up_data_i.mag_a[DataW-1:HalfW] * up_data_i.mag_b[DataW-1:HalfW];
  end

  // sum of the cross terms
  always_comb begin
    s3_d.op     = s2_q.op;
    s3_d.neg    = s2_q.neg;
    s3_d.as_val = s2_q.as_val;
    s3_d.as_ok  = s2_q.as_ok;
    s3_d.mid    = {1'b0, s2_q.pp_lh} + {1'b0, s2_q.pp_hl};
    s3_d.pp_ll  = s2_q.pp_ll;
    s3_d.pp_hh  = s2_q.pp_hh;
  end

  // final 128-bit product
  always_comb begin
    s4_d.op     = s3_q.op;
    s4_d.neg    = s3_q.neg;
    s4_d.as_val = s3_q.as_val;
    s4_d.as_ok  = s3_q.as_ok;
    s4_d.prod   = {s3_q.pp_hh, s3_q.pp_ll}
                + {{(ProdW-DataW-1-HalfW){1'b0}}, s3_q.mid, {HalfW{1'b0}}};
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en2) v2_q <= up_valid_i;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en2 && up_valid_i) s2_q <= s2_d;
    if (en3 && v2_q)       s3_q <= s3_d;
    if (en4 && v3_q)       s4_q <= s4_d;
  end

  assign dn_valid_o = v4_q;
  assign dn_data_o  = s4_q;

endmodule

`default_nettype wire

// ===== src/cfa_finish.sv =====
// last two stages: rounding and range check, then sign and result select
`default_nettype none

module cfa_finish
  import cfa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              up_valid_i,
  output logic                   up_en_o,
  input  wire s4_t               up_data_i,
  output logic                   dn_valid_o,
  input  wire logic              dn_en_i,
  output logic [DataW-1:0]       result_o,
  output logic                   overflow_o
);

  logic             v5_q, v6_q;
  logic             en5, en6;
  s5_t              s5_d, s5_q;
  logic [DataW:0]   rounded;
  logic             q_round;
  logic [DataW-1:0] signed_val;
  logic             sign_ok;
  logic [DataW-1:0] result_d, result_q;
  logic             ovf_d, ovf_q;

  assign en6     = !v6_q || dn_en_i;
  assign en5     = !v5_q || en6;
  assign up_en_o = en5;

  // round half away from zero on the dropped fraction bits
  assign q_round = up_data_i.prod[FracW-1];
  assign rounded = {1'b0, up_data_i.prod[DataW+FracW-1:FracW]}
                 + {{DataW{1'b0}}, q_round};

  always_comb begin
    s5_d.op     = up_data_i.op;
    s5_d.neg    = up_data_i.neg;
    s5_d.as_val = up_data_i.as_val;
    s5_d.as_ok  = up_data_i.as_ok;
    if (up_data_i.op == OP_QMUL) begin
      s5_d.mag     = rounded[DataW-1:0];
      s5_d.mag_ovf = (up_data_i.prod[ProdW-1:DataW+FracW] != '0) || rounded[DataW];
    end else begin
      s5_d.mag     = up_data_i.prod[DataW-1:0];
      s5_d.mag_ovf = (up_data_i.prod[ProdW-1:DataW] != '0);
    end
  end

  // apply the product sign; negative results may reach the most negative value
  assign signed_val = s5_q.neg ? (~s5_q.mag + {{(DataW-1){1'b0}}, 1'b1}) : s5_q.mag;
  assign sign_ok    = !s5_q.mag[DataW-1]
                   || (s5_q.neg && (s5_q.mag[DataW-2:0] == '0));

  // result select, zero on overflow
  always_comb begin
    unique case (s5_q.op)
      OP_ADD, OP_SUB: begin
        ovf_d = !s5_q.as_ok;
        result_d = s5_q.as_ok ? s5_q.as_val : '0;
      end
      OP_QMUL, OP_IMUL: begin
        ovf_d = s5_q.mag_ovf || !sign_ok;
        result_d = ovf_d ? '0 : signed_val;
      end
      default: begin
        ovf_d = 1'b1;
        result_d = '0;
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en5) v5_q <= up_valid_i;
      if (en6) v6_q <= v5_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en5 && up_valid_i) s5_q <= s5_d;
    if (en6 && v5_q) begin
      result_q <= result_d;
      ovf_q    <= ovf_d;
    end
  end

  assign dn_valid_o = v6_q;
  assign result_o   = result_q;
  assign overflow_o = ovf_q;

endmodule

`default_nettype wire

// ===== src/checked_fixed_point_alu.sv =====
// checked add, subtract, Q32.32 multiply and integer multiply on 64-bit operands
// pipeline: six register stages (operand, partial products, mid sum, product, rounding, result)
// throughput: one request per cycle unless out_stall_i holds it; the 32x32 partial-product
//   multiplier and the 128-bit product adder are each a pipeline stage of their own
// stall: each stage refills as soon as its content moves on, so bubbles are squeezed out
// reset: asynchronous active-low reset clears all valid bits; payload is not reset
`default_nettype none

module checked_fixed_point_alu
  import cfa_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [1:0]              op_i,
  input  wire logic signed [DataW-1:0] operand_a_i,
  input  wire logic signed [DataW-1:0] operand_b_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [DataW-1:0]      result_value_o,
  output logic                         overflow_o
);

  logic       front_en, mult_en, finish_en;
  logic       s1_valid, s4_valid;
  s1_t        s1_data;
  s4_t        s4_data;
  logic [DataW-1:0] result;

  // operand stage
  cfa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .up_valid_i  (in_valid_i),
    .up_en_o     (front_en),
    .op_i        (op_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .dn_valid_o  (s1_valid),
    .dn_en_i     (mult_en),
    .dn_data_o   (s1_data)
  );

  // multiplier stages
  cfa_mult u_mult (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (s1_valid),
    .up_en_o    (mult_en),
    .up_data_i  (s1_data),
    .dn_valid_o (s4_valid),
    .dn_en_i    (finish_en),
    .dn_data_o  (s4_data)
  );

  // rounding, sign and output register
  cfa_finish u_finish (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (s4_valid),
    .up_en_o    (finish_en),
    .up_data_i  (s4_data),
    .dn_valid_o (out_valid_o),
    .dn_en_i    (!out_stall_i),
    .result_o   (result),
    .overflow_o (overflow_o)
  );

  assign in_stall_o     = !front_en;
  assign result_value_o = result;

endmodule

`default_nettype wire
